FILE: rtl/core/ipv6x_pkg.sv
package ipv6x_pkg;

  // Fixed address geometry.
  localparam int unsigned GROUP_COUNT = 8;
  localparam int unsigned GROUP_CHARS = 4;

  // Character codes.
  localparam logic [7:0]  COLON_CODE = 8'h3A;
  localparam logic [31:0] ZERO_GROUP = 32'h3030_3030;

  // One input transaction: a single address character.
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } ipv6x_in_t;

  // One output transaction: a single expanded group.
  typedef struct packed {
    logic [31:0] group_text;
    logic [2:0]  group_index;
    logic        format_error;
    logic        last_group;
  } ipv6x_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       char_en;
    logic       emit_load;
    logic       clear;
    logic [2:0] emit_idx;
  } ipv6x_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;
  } ipv6x_status_t;

endpackage

FILE: rtl/core/ipv6x_ctrl.sv
module ipv6x_ctrl
  import ipv6x_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_stall_o,
  input  ipv6x_status_t status_i,
  output ipv6x_cmd_t    cmd_o
);

  typedef enum logic {
    S_COLLECT,
    S_EMIT
  } state_e;

  localparam logic [2:0] LAST_IDX = 3'(GROUP_COUNT - 1);

  state_e     state_q, state_d;
  logic [2:0] idx_q, idx_d;
  logic       char_en;
  logic       emit_load;

  // Characters are taken only while collecting; emission blocks the input.
  assign in_stall_o = (state_q == S_EMIT);
  assign char_en    = in_valid_i && (state_q == S_COLLECT);
  assign emit_load  = (state_q == S_EMIT) && status_i.slot_free;

  // Next state and group counter.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      S_COLLECT: begin
        if (char_en && in_last_i) begin
          state_d = S_EMIT;
          idx_d   = '0;
        end
      end
      S_EMIT: begin
        if (emit_load) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == LAST_IDX) begin
            state_d = S_COLLECT;
          end
        end
      end
      default: begin
        state_d = S_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_COLLECT;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // The state is cleared together with loading the final group.
  always_comb begin
    cmd_o.char_en   = char_en;
    cmd_o.emit_load = emit_load;
    cmd_o.clear     = emit_load && (idx_q == LAST_IDX);
    cmd_o.emit_idx  = idx_q;
  end

  a_last_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_load && idx_q == LAST_IDX) |=> (state_q == S_COLLECT))
    else $error("controller did not return to collecting after the last group");

  a_idx_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && !emit_load) |=> $stable(idx_q))
    else $error("group counter moved without a load");

  a_emit_starts_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_en && in_last_i) |=> (state_q == S_EMIT && idx_q == 3'd0))
    else $error("emission did not start at group zero");

endmodule

FILE: rtl/core/ipv6x_datapath.sv
module ipv6x_datapath
  import ipv6x_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ipv6x_in_t     in_data_i,
  input  ipv6x_cmd_t    cmd_i,
  output ipv6x_status_t status_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ipv6x_out_t    out_data_o
);

  localparam logic [3:0] COUNT4 = 4'(GROUP_COUNT);
  localparam logic [2:0] CHARS3 = 3'(GROUP_CHARS);
  localparam logic [2:0] LAST_IDX = 3'(GROUP_COUNT - 1);

  logic [31:0] grp_q, grp_d;
  logic [2:0]  len_q, len_d;
  logic [3:0]  head_q, head_d;
  logic [3:0]  tail_q, tail_d;
  logic        gap_q, gap_d;
  logic        prev_q, prev_d;
  logic        err_q, err_d;
  logic [31:0] store_q [GROUP_COUNT];

  logic        wr_en;
  logic [2:0]  wr_idx;
  logic [31:0] wr_data;
  logic        is_colon;
  logic        finish;
  logic [3:0]  total_q;
  logic [3:0]  total_f;

  ipv6x_out_t  out_q, out_d;
  logic        out_valid_q;
  logic [3:0]  tail_pos;
  logic [3:0]  tail_src;
  logic [31:0] sel_text;

  assign is_colon = (in_data_i.char_code == COLON_CODE);
  assign total_q  = head_q + tail_q;
  assign wr_idx   = total_q[2:0];

  // Character parsing, group finishing and end-of-address checks.
  always_comb begin
    grp_d   = grp_q;
    len_d   = len_q;
    head_d  = head_q;
    tail_d  = tail_q;
    gap_d   = gap_q;
    prev_d  = prev_q;
    err_d   = err_q;
    wr_en   = 1'b0;
    wr_data = grp_q;
    finish  = 1'b0;
    total_f = '0;
    if (cmd_i.clear) begin
      grp_d  = ZERO_GROUP;
      len_d  = '0;
      head_d = '0;
      tail_d = '0;
      gap_d  = 1'b0;
      prev_d = 1'b0;
      err_d  = 1'b0;
    end else if (cmd_i.char_en) begin
      if (is_colon) begin
        if (len_q != 3'd0) begin
          finish = 1'b1;
        end else if (prev_q) begin
          if (gap_q) begin
            err_d = 1'b1;
          end else begin
            gap_d = 1'b1;
          end
        end
        prev_d = 1'b1;
      end else begin
        if (len_q >= CHARS3) begin
          err_d = 1'b1;
        end else begin
          len_d = len_q + 3'd1;
        end
        grp_d  = {grp_q[23:0], in_data_i.char_code};
        prev_d = 1'b0;
        finish = in_data_i.last_char;
      end

      // A finished group goes to the next free store slot.
      if (finish) begin
        if (total_q >= COUNT4) begin
          err_d = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_data = grp_d;
          if (gap_d) begin
            tail_d = tail_q + 4'd1;
          end else begin
            head_d = head_q + 4'd1;
          end
        end
        grp_d = ZERO_GROUP;
        len_d = '0;
      end

      // Group count checks at the end of the address.
      if (in_data_i.last_char) begin
        total_f = head_d + tail_d;
        if (gap_d && total_f >= COUNT4) begin
          err_d = 1'b1;
        end
        if (!gap_d && total_f < COUNT4) begin
          err_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q  <= ZERO_GROUP;
      len_q  <= '0;
      head_q <= '0;
      tail_q <= '0;
      gap_q  <= 1'b0;
      prev_q <= 1'b0;
      err_q  <= 1'b0;
    end else begin
      grp_q  <= grp_d;
      len_q  <= len_d;
      head_q <= head_d;
      tail_q <= tail_d;
      gap_q  <= gap_d;
      prev_q <= prev_d;
      err_q  <= err_d;
    end
  end

  // Group store, written only by finished groups.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_idx] <= wr_data;
    end
  end

  // Select the text of the group being emitted; the gap reads as zeros.
  assign tail_pos = {1'b0, cmd_i.emit_idx} + tail_q;
  assign tail_src = {1'b0, cmd_i.emit_idx} + total_q - COUNT4;

  always_comb begin
    sel_text = ZERO_GROUP;
    if (gap_q) begin
      if ({1'b0, cmd_i.emit_idx} < head_q) begin
        sel_text = store_q[cmd_i.emit_idx];
      end else if (tail_pos >= COUNT4) begin
        sel_text = store_q[tail_src[2:0]];
      end
    end else if ({1'b0, cmd_i.emit_idx} < total_q) begin
      sel_text = store_q[cmd_i.emit_idx];
    end
  end

  // Output register decouples emission from the downstream stall.
  assign status_o.slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_d              = out_q;
    out_d.group_text   = sel_text;
    out_d.group_index  = cmd_i.emit_idx;
    out_d.format_error = err_q;
    out_d.last_group   = (cmd_i.emit_idx == LAST_IDX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q + tail_q) <= COUNT4)
    else $error("more than eight groups stored");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CHARS3)
    else $error("group length exceeds four characters");

  a_tail_needs_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !gap_q |-> (tail_q == 4'd0))
    else $error("tail groups recorded without a double colon");

endmodule

FILE: rtl/core/ipv6_text_expander_core.sv
// Sequence: a character transaction is absorbed into the parser state when accepted; eight group
// transactions follow the last character, once the controller has entered its emit state.
// Throughput: one character per cycle while collecting, then the groups are emitted one by
// one through the output register, which holds while out_stall_i is asserted.
// Reset: rst_ni is asynchronous and active low; it clears all parser state and the output
// valid. The group store is not reset and only written entries are ever read.
module ipv6_text_expander_core
  import ipv6x_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  ipv6x_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output ipv6x_out_t out_data_o
);

  ipv6x_cmd_t    cmd;
  ipv6x_status_t status;

  // Sequencer for collection and emission.
  ipv6x_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last_char),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Parser state, group store and output register.
  ipv6x_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
